@@ rtl/assert_macros.svh @@
// Assertion macros used by the display scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("Assertion failed.");

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

@@ rtl/ssd_pkg.sv @@
// Types, constants and lookup functions for the serial digit display scanner.
package ssd_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int CODE_W         = 4;
    localparam int SEL_W          = 8;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;

    localparam logic ACTION_RX   = 1'b0;
    localparam logic ACTION_SCAN = 1'b1;

    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_TX      = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_C    = 8'h43;
    localparam logic [7:0] ASCII_N    = 8'h4E;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] SEG_DARK   = 8'hFF;

    localparam logic [1:0] REPLY_FIRST = 2'd0;
    localparam logic [1:0] REPLY_MID   = 2'd1;
    localparam logic [1:0] REPLY_LAST  = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [SEL_W-1:0] digit_select;
        logic [7:0]       segments;
        logic [7:0]       tx_byte;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic shift_en;
        logic clear_en;
    } cell_ctrl_t;

    function automatic logic [7:0] seg_lookup(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'd192;
            4'd1:    seg = 8'd249;
            4'd2:    seg = 8'd164;
            4'd3:    seg = 8'd176;
            4'd4:    seg = 8'd153;
            4'd5:    seg = 8'd146;
            4'd6:    seg = 8'd130;
            4'd7:    seg = 8'd184;
            4'd8:    seg = 8'd128;
            4'd9:    seg = 8'd144;
            default: seg = SEG_DARK;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            REPLY_FIRST: b = 8'h4F;
            REPLY_MID:   b = 8'h4B;
            REPLY_LAST:  b = ASCII_LF;
            default:     b = ASCII_LF;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/ssd_cell.sv @@
// One digit cell: holds a digit code, shifts it on or clears it, and adds it to the read chain when selected.
module ssd_cell
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [CODE_W-1:0] shift_in,
    input  logic              read_sel,
    input  logic [CODE_W-1:0] read_in,
    output logic [CODE_W-1:0] code,
    output logic [CODE_W-1:0] read_out
);

    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;

    always_comb
    begin
        code_next = code_reg;
        if (ctrl.clear_en)
        begin
            code_next = BLANK_CODE;
        end
        else if (ctrl.shift_en)
        begin
            code_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= BLANK_CODE;
        end
        else
        begin
            code_reg <= code_next;
        end
    end

    assign code     = code_reg;
    assign read_out = read_in | (read_sel ? code_reg : {CODE_W{1'b0}});

endmodule

@@ rtl/serial_digit_display_scanner_core.sv @@
// Top level of the serial digit display scanner: input stage, digit cell row and result stage.
// The scanner takes one item per clock cycle while in_ready is high. An item first lands in a
// one-entry input register, so a new item is taken while a finished result still waits at the
// output register. A scan tick or a received byte is handled from the input register once the
// output register is free and no reply is being sent, and a scan tick's display result is
// registered in the output register. A line feed keeps the single output register busy while
// the reply bytes 'O', 'K' and line feed are sent, and items behind it wait in the input register
// during that time. Digits are held in a row of NUM_DIGITS cells that shift towards the oldest
// position when a digit arrives; the scanned cell is picked out along a read chain through the row.
// There is no clearing pass after reset: every cell resets to blank at once.
module serial_digit_display_scanner_core
    import ssd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

`include "assert_macros.svh"

    localparam int POS_W = $clog2(NUM_DIGITS);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    in_item_t  hold_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic [1:0] reply_idx_reg;
    logic [1:0] reply_idx_next;
    logic [POS_W-1:0] scan_pos_reg;
    logic [POS_W-1:0] scan_pos_next;

    logic in_fire;
    logic out_fire;
    logic out_free;
    logic proc_fire;
    logic is_scan;
    logic is_digit;
    logic is_clear;
    logic is_lf;

    cell_ctrl_t cell_ctrl;
    logic [CODE_W-1:0] cell_code  [NUM_DIGITS];
    logic [CODE_W-1:0] read_chain [NUM_DIGITS+1];
    logic [SEL_W-1:0]  scan_sel;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign proc_fire = hold_valid_reg && (reply_idx_reg == REPLY_FIRST) && out_free;
    assign in_ready = !hold_valid_reg || proc_fire;

    assign is_scan  = hold_item_reg.action == ACTION_SCAN;
    assign is_digit = (hold_item_reg.rx_byte >= ASCII_ZERO) &&
                      (hold_item_reg.rx_byte <= ASCII_NINE);
    assign is_clear = (hold_item_reg.rx_byte == ASCII_C) ||
                      (hold_item_reg.rx_byte == ASCII_N);
    assign is_lf    = hold_item_reg.rx_byte == ASCII_LF;

    assign cell_ctrl.shift_en = proc_fire && !is_scan && is_digit;
    assign cell_ctrl.clear_en = proc_fire && !is_scan && is_clear;

    assign read_chain[0] = {CODE_W{1'b0}};

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        logic [CODE_W-1:0] shift_in;
        if (k == 0)
        begin : g_head
            assign shift_in = hold_item_reg.rx_byte[CODE_W-1:0];
        end
        else
        begin : g_body
            assign shift_in = cell_code[k-1];
        end

        ssd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (shift_in),
            .read_sel (scan_pos_reg == POS_W'(k)),
            .read_in  (read_chain[k]),
            .code     (cell_code[k]),
            .read_out (read_chain[k+1])
        );
    end

    for (genvar k = 0; k < SEL_W; k++)
    begin : g_sel
        if (k < NUM_DIGITS)
        begin : g_live
            assign scan_sel[k] = scan_pos_reg == POS_W'(k);
        end
        else
        begin : g_dead
            assign scan_sel[k] = 1'b0;
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            hold_valid_next = 1'b0;
        end

        scan_pos_next = scan_pos_reg;
        if (proc_fire && is_scan)
        begin
            if (scan_pos_reg == POS_W'(NUM_DIGITS - 1))
            begin
                scan_pos_next = {POS_W{1'b0}};
            end
            else
            begin
                scan_pos_next = scan_pos_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        reply_idx_next = reply_idx_reg;

        if (proc_fire && is_scan)
        begin
            out_valid_next             = 1'b1;
            out_item_next.kind         = KIND_DISPLAY;
            out_item_next.digit_select = scan_sel;
            out_item_next.segments     = seg_lookup(read_chain[NUM_DIGITS]);
            out_item_next.tx_byte      = 8'h00;
            out_item_next.last         = 1'b1;
        end
        else if (proc_fire && is_lf)
        begin
            out_valid_next             = 1'b1;
            out_item_next.kind         = KIND_TX;
            out_item_next.digit_select = {SEL_W{1'b0}};
            out_item_next.segments     = SEG_DARK;
            out_item_next.tx_byte      = reply_byte(REPLY_FIRST);
            out_item_next.last         = 1'b0;
            reply_idx_next             = REPLY_MID;
        end
        else if (out_fire && (reply_idx_reg != REPLY_FIRST))
        begin
            out_valid_next             = 1'b1;
            out_item_next.kind         = KIND_TX;
            out_item_next.digit_select = {SEL_W{1'b0}};
            out_item_next.segments     = SEG_DARK;
            out_item_next.tx_byte      = reply_byte(reply_idx_reg);
            out_item_next.last         = reply_idx_reg == REPLY_LAST;
            reply_idx_next             = (reply_idx_reg == REPLY_LAST) ? REPLY_FIRST :
                                         REPLY_LAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            reply_idx_reg  <= REPLY_FIRST;
            scan_pos_reg   <= {POS_W{1'b0}};
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            reply_idx_reg  <= reply_idx_next;
            scan_pos_reg   <= scan_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_item_reg <= in_item;
        end
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `ASSERT_IMPLIES(a_reply_pending, clk, rst_n, reply_idx_reg != REPLY_FIRST,
                    out_valid_reg && (out_item_reg.kind == KIND_TX) && !out_item_reg.last)
    `ASSERT_IMPLIES(a_tx_dark, clk, rst_n, out_valid_reg && (out_item_reg.kind == KIND_TX),
                    (out_item_reg.digit_select == '0) && (out_item_reg.segments == SEG_DARK))
    `ASSERT_IMPLIES(a_sel_onehot, clk, rst_n, out_valid_reg && (out_item_reg.kind == KIND_DISPLAY),
                    $onehot0(out_item_reg.digit_select) && out_item_reg.last)
    `ASSERT_ALWAYS(a_pos_range, clk, rst_n, scan_pos_reg <= POS_W'(NUM_DIGITS - 1))
    `ASSERT_NEXT(a_no_proc_in_reply, clk, rst_n, proc_fire && !is_scan && is_lf,
                 !proc_fire && (reply_idx_reg == REPLY_MID))

endmodule
